// ----- rtl/abq_pkg.sv -----
// ----------------------------------------------------------------------------
// abq_pkg - shared constants and types for the audio burst qualifier
// Sizes derived from the burst length limit, register map, state encoding.
// ----------------------------------------------------------------------------
package abq_pkg;

    // Longest burst in samples; a burst that reaches it is closed as overflow
    localparam int unsigned MAX_BURST = 1048576;

    localparam int LEN_W    = $clog2(MAX_BURST + 1);   // burst length, counts
    localparam int SUM_W    = 16 + LEN_W;              // signed level sum
    localparam int DVD_W    = SUM_W + 1;               // 2*sum + width, signed
    localparam int DEN_W    = LEN_W + 1;               // 2*width
    localparam int CNT_W    = $clog2(DVD_W);           // divider step counter
    localparam int CMP_W    = (LEN_W > 21) ? LEN_W : 21;
    localparam int FIVE_W   = LEN_W + 3;

    localparam int THR_W    = 15;
    localparam int HOLD_W   = 16;
    localparam int MINW_W   = 21;
    localparam int WIDTH_W  = 21;
    localparam int MEAN_W   = 16;
    localparam int PADDR_W  = 4;

    localparam logic [THR_W-1:0]  THR_RST  = 15'd4096;
    localparam logic [HOLD_W-1:0] HOLD_RST = 16'd32;
    localparam logic [MINW_W-1:0] MINW_RST = 21'd11025;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLD_LEN  = 2'd1,
        REG_MIN_WIDTH = 2'd2
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // taking samples
        S_PREP = 5'b00010,   // form 2*sum + width
        S_ABS  = 5'b00100,   // sign and magnitude of dividend
        S_DIV  = 5'b01000,   // one quotient bit per cycle
        S_DONE = 5'b10000    // waiting for the output register
    } t_state;

endpackage

// ----- rtl/audio_burst_qualifier.sv -----
// ----------------------------------------------------------------------------
// audio_burst_qualifier - burst detector and qualifier for a mono audio stream
//
// s_axis carries one signed 16-bit sample per beat. m_axis carries one beat
// per finished burst: start index, width and rounded mean in tdata, the
// accepted and overflow flags in tuser. Registers threshold, hold_length and
// min_width sit on the APB port at byte addresses 0, 4 and 8.
// A sample that does not close a burst is taken in S_IDLE; s_axis_tready
// stays high and samples may stream back to back. A sample that closes a
// burst starts the mean computation: S_PREP forms the signed dividend, S_ABS
// its magnitude, then a restoring divider in S_DIV shifts out one quotient
// bit per cycle over DVD_W (38) steps, then S_DONE loads the output register.
// That sample therefore holds s_axis_tready low through all of these states,
// and m_axis_tvalid rises when S_DONE loads the output register.
// The output register frees the input side: a new burst may run while a
// result waits. If a second burst closes before the first result is taken,
// the block waits in its final step with s_axis_tready low until
// m_axis_tready frees the register. Reset (synchronous, active low) restores
// the register defaults, clears the sample index and ends any open burst.
// ----------------------------------------------------------------------------
module audio_burst_qualifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [15:0] left_sample
    // burst results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [71:0]                 m_axis_tdata,   // [31:0] burst_start,
                                                        // [52:32] burst_width,
                                                        // [68:53] mean_level
    output logic [1:0]                  m_axis_tuser,   // [0] accepted, [1] overflow
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import abq_pkg::*;

    // configuration
    logic [THR_W-1:0]   r_thr;
    logic [HOLD_W-1:0]  r_hold_len;
    logic [MINW_W-1:0]  r_min_w;

    // burst tracking
    t_state             r_state;
    logic [HOLD_W-1:0]  r_hold;
    logic [31:0]        r_idx;
    logic [31:0]        r_start;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_neg;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ovf;

    // divider
    logic [DVD_W-1:0]   r_dvd;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sign;

    // output register
    logic               r_ovld;
    logic [31:0]        r_o_start;
    logic [WIDTH_W-1:0] r_o_width;
    logic [MEAN_W-1:0]  r_o_mean;
    logic               r_o_acc;
    logic               r_o_ovf;

    logic               w_wr;
    t_reg_idx           w_reg;
    logic               w_in_acc;
    logic               w_slot_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_reg  = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (w_reg)
            REG_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, r_thr};
            REG_HOLD_LEN:  prdata = {{(32-HOLD_W){1'b0}}, r_hold_len};
            REG_MIN_WIDTH: prdata = {{(32-MINW_W){1'b0}}, r_min_w};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_hold_len <= HOLD_RST;
            r_min_w    <= MINW_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_THRESHOLD: r_thr      <= pwdata[THR_W-1:0];
                REG_HOLD_LEN:  r_hold_len <= pwdata[HOLD_W-1:0];
                REG_MIN_WIDTH: r_min_w    <= pwdata[MINW_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- per-sample update ----------------
    logic signed [16:0]  w_s;
    logic        [16:0]  w_mag;
    logic signed [16:0]  w_thr_p;
    logic                w_loud;
    logic                w_open;
    logic [HOLD_W-1:0]   w_hold_a;
    logic                w_active;
    logic [LEN_W-1:0]    w_len_n;
    logic [LEN_W-1:0]    w_pos_n;
    logic [LEN_W-1:0]    w_neg_n;
    logic [SUM_W-1:0]    w_sum_n;
    logic [HOLD_W-1:0]   w_hold_dec;
    logic                w_ovf_n;
    logic                w_end;

    assign w_s     = {s_axis_tdata[15], s_axis_tdata};
    assign w_mag   = w_s[16] ? 17'(-w_s) : 17'(w_s);
    assign w_thr_p = $signed({2'b00, r_thr});
    assign w_loud  = w_mag > {2'b00, r_thr};
    assign w_open  = w_loud && (r_hold == '0);

    always_comb begin
        if (!w_loud)
            w_hold_a = r_hold;
        else if (r_hold_len == '0)
            w_hold_a = HOLD_W'(1);
        else
            w_hold_a = r_hold_len;
    end

    assign w_active   = (w_hold_a != '0);
    assign w_len_n    = (w_open ? '0 : r_len) + LEN_W'(1);
    assign w_pos_n    = (w_open ? '0 : r_pos) + LEN_W'(w_s > w_thr_p);
    assign w_neg_n    = (w_open ? '0 : r_neg) + LEN_W'(w_s < -w_thr_p);
    assign w_sum_n    = (w_open ? '0 : r_sum) + SUM_W'(w_s);
    assign w_hold_dec = w_hold_a - HOLD_W'(1);
    assign w_ovf_n    = (w_len_n == LEN_W'(MAX_BURST));
    assign w_end      = w_active && ((w_hold_dec == '0) || w_ovf_n);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_slot_free   = !r_ovld || m_axis_tready;

    // ---------------- divider step ----------------
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_trial;
    logic             w_qbit;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_qbit  = !w_trial[DEN_W];

    // ---------------- qualification at output ----------------
    logic [FIVE_W-1:0] w_pos5;
    logic [FIVE_W-1:0] w_neg5;
    logic [CMP_W-1:0]  w_len_c;
    logic              w_acc;
    logic [MEAN_W-1:0] w_q;

    assign w_pos5  = {r_pos, 2'b00} + FIVE_W'(r_pos);
    assign w_neg5  = {r_neg, 2'b00} + FIVE_W'(r_neg);
    assign w_len_c = CMP_W'(r_len);
    assign w_acc   = !r_ovf && (w_len_c > CMP_W'(r_min_w))
                     && (w_pos5 > FIVE_W'(r_len)) && (w_neg5 > FIVE_W'(r_len));
    assign w_q     = r_dvd[MEAN_W-1:0];

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hold  <= '0;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            // in the final step the load below takes over the valid flag
            if (r_ovld && m_axis_tready && (r_state != S_DONE))
                r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_idx <= r_idx + 32'd1;
                        if (w_open)
                            r_start <= r_idx;
                        if (w_active) begin
                            r_len  <= w_len_n;
                            r_pos  <= w_pos_n;
                            r_neg  <= w_neg_n;
                            r_sum  <= w_sum_n;
                            r_hold <= w_end ? '0 : w_hold_dec;
                            r_ovf  <= w_ovf_n;
                        end
                        if (w_end)
                            r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_dvd   <= {r_sum, 1'b0} + DVD_W'(r_len);
                    r_den   <= {r_len, 1'b0};
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_sign  <= r_dvd[DVD_W-1];
                    r_dvd   <= r_dvd[DVD_W-1] ? -r_dvd : r_dvd;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_qbit ? w_trial[DEN_W-1:0] : w_shift[DEN_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DVD_W - 1))
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_ovld    <= 1'b1;
                        r_o_start <= r_start;
                        r_o_width <= w_len_c[WIDTH_W-1:0];
                        r_o_acc   <= w_acc;
                        r_o_ovf   <= r_ovf;
                        r_o_mean  <= r_sign ? -w_q : w_q;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {3'b000, r_o_mean, r_o_width, r_o_start};
    assign m_axis_tuser  = {r_o_ovf, r_o_acc};

`ifndef SYNTHESIS
    // no burst may stay open while its mean is being worked out
    a_closed_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_hold == '0))
        else $error("burst still open during division");

    // a closing sample always starts the mean computation
    a_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_end) |=> (r_state == S_PREP))
        else $error("closed burst did not start division");

    // restoring divider keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    // the rounded mean magnitude never exceeds 15 bits
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_dvd[DVD_W-1:MEAN_W-1] == '0))
        else $error("mean quotient too wide");

    // a result waiting unserved is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> (r_ovld && $stable(r_o_start)))
        else $error("pending result lost");
`endif

endmodule

// ----- test/audio_burst_qualifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_burst_qualifier_checker - burst tracker and report scoreboard
// Follows APB writes and every accepted sample beat with its own burst
// tracker. It queues the report each closed burst must produce, then checks
// m_axis beats and register reads against the queue and the tracked settings.
// ----------------------------------------------------------------------------
module audio_burst_qualifier_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [15:0] left_sample
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [71:0]                 m_axis_tdata,   // [31:0] burst_start,
                                                        // [52:32] burst_width,
                                                        // [68:53] mean_level
    input  logic [1:0]                  m_axis_tuser,   // [0] accepted, [1] overflow
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_reports_due
);
    import abq_pkg::*;

    typedef struct packed {
        logic [31:0]        start;
        logic [WIDTH_W-1:0] width;
        logic               accepted;
        logic [MEAN_W-1:0]  mean;
        logic               overflow;
    } t_burst_report;

    t_burst_report reports_due[$];

    // tracked registers
    int thr_reg;
    int hold_reg;
    int minw_reg;

    // tracked burst state
    int          hold_left;
    logic [31:0] sample_idx;
    logic [31:0] start_idx;
    int          burst_len;
    int          pos_cnt;
    int          neg_cnt;
    longint      level_sum;

    int fail_count = 0;
    int due_count  = 0;

    assign o_fail_count  = fail_count;
    assign o_reports_due = due_count;

    task automatic track_sample(input logic signed [15:0] smp);
        int            s;
        int            mag;
        logic          ovf;
        longint        num;
        longint        den;
        longint        quo;
        t_burst_report rep;
        s   = smp;
        mag = (s < 0) ? -s : s;
        sample_idx = sample_idx + 32'd1;
        if (mag > thr_reg) begin
            if (hold_left == 0) begin
                start_idx = sample_idx - 32'd1;
                burst_len = 0;
                pos_cnt   = 0;
                neg_cnt   = 0;
                level_sum = 0;
            end
            hold_left = (hold_reg == 0) ? 1 : hold_reg;
        end
        if (hold_left > 0) begin
            burst_len++;
            if (s > thr_reg)
                pos_cnt++;
            else if (s < -thr_reg)
                neg_cnt++;
            level_sum += s;
            hold_left--;
            ovf = (burst_len >= int'(MAX_BURST));
            if (hold_left == 0 || ovf) begin
                // round half up on the rational, then truncate toward zero
                num = 2 * level_sum + burst_len;
                den = 2 * longint'(burst_len);
                quo = num / den;
                rep.start    = start_idx;
                rep.width    = WIDTH_W'(burst_len);
                rep.accepted = !ovf && burst_len > minw_reg &&
                               longint'(pos_cnt) * 5 > burst_len &&
                               longint'(neg_cnt) * 5 > burst_len;
                rep.mean     = quo[MEAN_W-1:0];
                rep.overflow = ovf;
                hold_left    = 0;
                reports_due.push_back(rep);
            end
        end
    endtask

    task automatic field_check(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin
        t_burst_report rep;
        if (!i_rst_n) begin
            thr_reg    = THR_RST;
            hold_reg   = HOLD_RST;
            minw_reg   = MINW_RST;
            hold_left  = 0;
            sample_idx = '0;
            start_idx  = '0;
            burst_len  = 0;
            pos_cnt    = 0;
            neg_cnt    = 0;
            level_sum  = 0;
            reports_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_THRESHOLD: thr_reg  = pwdata[THR_W-1:0];
                        REG_HOLD_LEN:  hold_reg = pwdata[HOLD_W-1:0];
                        REG_MIN_WIDTH: minw_reg = pwdata[MINW_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_THRESHOLD: field_check("threshold", thr_reg, prdata);
                        REG_HOLD_LEN:  field_check("hold_length", hold_reg, prdata);
                        REG_MIN_WIDTH: field_check("min_width", minw_reg, prdata);
                        default: ;
                    endcase
                end
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (reports_due.size() == 0) begin
                    fail_count++;
                    $error("burst report beat with none due: start 0x%0h width %0d",
                           m_axis_tdata[31:0], m_axis_tdata[52:32]);
                end else begin
                    rep = reports_due.pop_front();
                    field_check("burst_start", rep.start, m_axis_tdata[31:0]);
                    field_check("burst_width", 32'(rep.width), 32'(m_axis_tdata[52:32]));
                    field_check("mean_level", 32'(rep.mean), 32'(m_axis_tdata[68:53]));
                    field_check("accepted", 32'(rep.accepted), 32'(m_axis_tuser[0]));
                    field_check("overflow", 32'(rep.overflow), 32'(m_axis_tuser[1]));
                end
            end
            if (s_axis_tvalid && s_axis_tready === 1'b1)
                track_sample(s_axis_tdata);
        end
        due_count = reports_due.size();
    end

endmodule

// ----- test/audio_burst_qualifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_burst_qualifier_tb - stimulus and verdict for the burst qualifier
// Drives sample beats and APB register traffic: a directed pass over the
// register extremes and edge samples, random phases of shaped bursts under
// varied settings with random stalls on both streams in all but one, and a
// final stall-free phase. Checking is in the checker.
// ----------------------------------------------------------------------------
module audio_burst_qualifier_tb;
    import abq_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;   // unmapped, writes ignored
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_WAIT  = 60;     // room for a divide still in flight

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;    // [15:0] left_sample
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [71:0]        m_axis_tdata;    // [31:0] burst_start, [52:32] burst_width,
                                         // [68:53] mean_level
    logic [1:0]         m_axis_tuser;    // [0] accepted, [1] overflow
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int reports_due;
    bit idle_on  = 1'b1;
    int rx_stall = 0;
    int cur_thr;
    int cur_hold;

    audio_burst_qualifier DUT (.*);

    audio_burst_qualifier_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_reports_due (reports_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("audio_burst_qualifier_tb NOT OK");
        $finish;
    end

    // result side back-pressure, random stalls while idle_on is set
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall      <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // upper pwdata bits random so masking gets exercised
    task automatic cfg_write(input logic [1:0] idx, input int unsigned value,
                             input int field_w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() << field_w) | value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_read(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int thr, input int hold, input int minw);
        cur_thr  = thr & 32'h7FFF;
        cur_hold = hold & 32'hFFFF;
        cfg_write(REG_THRESHOLD, cur_thr, THR_W);
        cfg_write(REG_HOLD_LEN, cur_hold, HOLD_W);
        cfg_write(REG_MIN_WIDTH, minw & 32'h1FFFFF, MINW_W);
        cfg_write(REG_UNUSED, $urandom(), 0);
        cfg_read(REG_THRESHOLD);
        cfg_read(REG_HOLD_LEN);
        cfg_read(REG_MIN_WIDTH);
    endtask

    task automatic push_sample(input logic [15:0] smp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // all reports drained, then room for a divide still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (reports_due == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [15:0] loud_value(input int thr);
        int m;
        if (thr >= 32767 || $urandom_range(0, 1) == 1) begin
            m = $urandom_range(thr + 1, 32768);
            return 16'(-m);
        end
        return 16'($urandom_range(thr + 1, 32767));
    endfunction

    function automatic logic [15:0] quiet_value(input int thr);
        int m;
        m = $urandom_range(0, thr);
        return ($urandom_range(0, 1) == 1) ? 16'(-m) : 16'(m);
    endfunction

    // mostly shaped bursts: loud runs with quiet gaps near the hold length
    task automatic run_phase(input int n_items);
        int count;
        int seg_len;
        int kind;
        count = 0;
        while (count < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                push_sample(16'($urandom()));
                count++;
            end else if (kind < 6) begin
                seg_len = $urandom_range(1, 30);
                repeat (seg_len) begin
                    push_sample(($urandom_range(0, 3) != 0) ? loud_value(cur_thr)
                                                           : quiet_value(cur_thr));
                    count++;
                end
            end else begin
                seg_len = $urandom_range(1, (cur_hold > 36) ? 40 : cur_hold + 4);
                repeat (seg_len) begin
                    push_sample(quiet_value(cur_thr));
                    count++;
                end
            end
        end
    endtask

    task automatic pick_random_config();
        int thr;
        int hold;
        int minw;
        thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                          : $urandom_range(50, 3000);
        case ($urandom_range(0, 7))
            0:       hold = 0;
            1:       hold = 1;
            2:       hold = $urandom_range(25, 40);
            default: hold = $urandom_range(2, 24);
        endcase
        case ($urandom_range(0, 7))
            0:       minw = 0;
            1:       minw = 32'h1FFFFF;
            default: minw = $urandom_range(0, 25);
        endcase
        set_config(thr, hold, minw);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset
        cfg_read(REG_THRESHOLD);
        cfg_read(REG_HOLD_LEN);
        cfg_read(REG_MIN_WIDTH);

        // zero threshold and zero hold: every nonzero sample is its own burst
        set_config(0, 0, 0);
        push_sample(16'sd0);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'h8000);
        push_sample(16'sd32767);
        push_sample(16'sd0);
        settle();

        // top threshold: only the most negative sample is loud
        set_config(32767, 3, 1);
        push_sample(16'sd32767);
        push_sample(16'h8000);
        push_sample(16'sd32767);
        push_sample(16'sd0);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'sd5);
        settle();

        // both polarities around a threshold, samples at the exact boundary
        set_config(100, 2, 2);
        push_sample(16'sd200);
        push_sample(-16'sd300);
        push_sample(16'sd50);
        push_sample(-16'sd7);
        push_sample(16'sd101);
        push_sample(-16'sd101);
        push_sample(16'sd100);
        push_sample(-16'sd100);
        settle();

        for (int p = 0; p < 8; p++) begin
            idle_on = (p != 3);
            pick_random_config();
            run_phase(200);
            settle();
        end

        idle_on = 1'b0;
        pick_random_config();
        run_phase(100);
        settle();

        if (fail_count == 0)
            $display("audio_burst_qualifier_tb OK");
        else
            $display("audio_burst_qualifier_tb NOT OK");
        $finish;
    end

endmodule
